[sv/rds_pkg.sv]
// shared types and constants for the region duration statistics block
// no dependencies
package rds_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int TIME_BITS_DEF  = 48;
	localparam int FIELD_BITS     = 48;
	localparam int CALL_BITS      = 32;
	localparam int TOTAL_BITS     = 64;
	localparam int DEPTH_BITS     = 32;
	localparam int TRIM_CALLS     = 4;

	typedef enum logic [1:0] {
		OP_BEGIN  = 2'd0,
		OP_END    = 2'd1,
		OP_DEPTH  = 2'd2,
		OP_REPORT = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         slot;
		logic [47:0]        timestamp;
		logic signed [15:0] depth_delta;
	} in_t;

	typedef struct packed {
		logic               slot_used;
		logic [47:0]        average_ticks;
		logic [47:0]        min_ticks;
		logic [47:0]        max_ticks;
		logic [31:0]        call_count;
		logic signed [31:0] depth_total;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_SORT,
		ST_WRITE,
		ST_TRIM,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd;
		logic calc;
		logic sort;
		logic wr;
		logic trim;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic report;
		logic zero_calls;
		logic div_last;
		logic out_busy;
	} stat_t;

endpackage

[sv/rds_ctrl.sv]
// controller state machine for the region duration statistics block
// depends on rds_pkg
module rds_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_ready,
	input  rds_pkg::stat_t stat,
	output rds_pkg::cmd_t  cmd
);

	rds_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rds_pkg::ST_IDLE: begin
				if (in_valid && stat.in_range) state_d = rds_pkg::ST_READ;
			end
			rds_pkg::ST_READ:  state_d = rds_pkg::ST_CALC;
			rds_pkg::ST_CALC: begin
				if (!stat.report) state_d = rds_pkg::ST_SORT;
				else if (stat.zero_calls) state_d = rds_pkg::ST_DONE;
				else state_d = rds_pkg::ST_TRIM;
			end
			rds_pkg::ST_SORT:  state_d = rds_pkg::ST_WRITE;
			rds_pkg::ST_WRITE: state_d = rds_pkg::ST_IDLE;
			rds_pkg::ST_TRIM:  state_d = rds_pkg::ST_DIV;
			rds_pkg::ST_DIV: begin
				if (stat.div_last) state_d = rds_pkg::ST_DONE;
			end
			rds_pkg::ST_DONE: begin
				if (!stat.out_busy || out_ready) state_d = rds_pkg::ST_IDLE;
			end
			default: state_d = rds_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			rds_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			rds_pkg::ST_READ:  cmd.rd = 1'b1;
			rds_pkg::ST_CALC:  cmd.calc = 1'b1;
			rds_pkg::ST_SORT:  cmd.sort = 1'b1;
			rds_pkg::ST_WRITE: cmd.wr = 1'b1;
			rds_pkg::ST_TRIM:  cmd.trim = 1'b1;
			rds_pkg::ST_DIV:   cmd.div_step = 1'b1;
			rds_pkg::ST_DONE:  cmd.load_out = !stat.out_busy || out_ready;
			default: cmd = '0;
		endcase
	end

endmodule

[sv/rds_datapath.sv]
// slot table, update arithmetic, trimmed mean divider and output register
// depends on rds_pkg
module rds_datapath #(
	parameter int SLOT_COUNT = rds_pkg::SLOT_COUNT_DEF,
	parameter int TIME_BITS  = rds_pkg::TIME_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rds_pkg::in_t   in_data,
	input  rds_pkg::cmd_t  cmd,
	output rds_pkg::stat_t stat,
	output logic           out_valid,
	input  logic           out_ready,
	output rds_pkg::out_t  out_data
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int T  = TIME_BITS;
	localparam int TB = rds_pkg::TOTAL_BITS;
	localparam int CB = rds_pkg::CALL_BITS;
	localparam int DB = rds_pkg::DEPTH_BITS;
	localparam int FB = rds_pkg::FIELD_BITS;

	logic [T-1:0]  start_mem [SLOT_COUNT];
	logic [TB-1:0] total_mem [SLOT_COUNT];
	logic [CB-1:0] calls_mem [SLOT_COUNT];
	logic [T-1:0]  min0_mem  [SLOT_COUNT];
	logic [T-1:0]  min1_mem  [SLOT_COUNT];
	logic [T-1:0]  max0_mem  [SLOT_COUNT];
	logic [T-1:0]  max1_mem  [SLOT_COUNT];
	logic [DB-1:0] depth_mem [SLOT_COUNT];

	logic [SLOT_COUNT-1:0] init_q;
	logic [SLOT_COUNT-1:0] used_q;

	logic [8:0]    slot9;
	logic [SW-1:0] idx_q;
	logic [1:0]    op_q;
	logic [T-1:0]  ts_q;
	logic [DB-1:0] delta_q;

	logic          rd_init_q;
	logic [T-1:0]  rd_start_q, rd_min0_q, rd_min1_q, rd_max0_q, rd_max1_q;
	logic [TB-1:0] rd_total_q;
	logic [CB-1:0] rd_calls_q;
	logic [DB-1:0] rd_depth_q;

	logic [T-1:0]  cur_start, cur_min0, cur_min1, cur_max0, cur_max1;
	logic [TB-1:0] cur_total;
	logic [CB-1:0] cur_calls;
	logic [DB-1:0] cur_depth;

	logic [T-1:0]  dur_q, mn1_q, mx1_q;
	logic [T-1:0]  new_start, new_min0, new_min1, new_max0, new_max1;
	logic [TB-1:0] new_total;
	logic [CB-1:0] new_calls;
	logic [DB-1:0] new_depth;
	logic          is_end;

	logic [TB-1:0] num_q;
	logic [CB-1:0] den_q;
	logic [CB-1:0] rem_q;
	logic [5:0]    cnt_q;
	logic [CB:0]   rem_try;
	logic          rem_ge;
	logic [FB-1:0] avg;

	logic          out_valid_q;
	rds_pkg::out_t out_q;

	assign slot9 = 9'(in_data.slot);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q   <= slot9[SW-1:0];
			op_q    <= in_data.op;
			ts_q    <= T'(in_data.timestamp);
			delta_q <= DB'(in_data.depth_delta);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_start_q <= start_mem[idx_q];
			rd_total_q <= total_mem[idx_q];
			rd_calls_q <= calls_mem[idx_q];
			rd_min0_q  <= min0_mem[idx_q];
			rd_min1_q  <= min1_mem[idx_q];
			rd_max0_q  <= max0_mem[idx_q];
			rd_max1_q  <= max1_mem[idx_q];
			rd_depth_q <= depth_mem[idx_q];
			rd_init_q  <= init_q[idx_q];
		end
	end

	always_comb begin
		cur_start = rd_init_q ? rd_start_q : '0;
		cur_total = rd_init_q ? rd_total_q : '0;
		cur_calls = rd_init_q ? rd_calls_q : '0;
		cur_min0  = rd_init_q ? rd_min0_q  : '1;
		cur_min1  = rd_init_q ? rd_min1_q  : '1;
		cur_max0  = rd_init_q ? rd_max0_q  : '0;
		cur_max1  = rd_init_q ? rd_max1_q  : '0;
		cur_depth = rd_init_q ? rd_depth_q : '0;
	end

	// duration, then second-place insertion, then swap at write
	always_ff @(posedge clk) begin
		if (cmd.calc) dur_q <= ts_q - cur_start;
		if (cmd.sort) begin
			mn1_q <= (cur_min1 > dur_q) ? dur_q : cur_min1;
			mx1_q <= (cur_max1 < dur_q) ? dur_q : cur_max1;
		end
	end

	assign is_end = (op_q == rds_pkg::OP_END) && used_q[idx_q];

	always_comb begin
		new_start = (op_q == rds_pkg::OP_BEGIN) ? ts_q : cur_start;
		new_depth = (op_q == rds_pkg::OP_DEPTH) ? cur_depth + delta_q : cur_depth;
		new_total = cur_total;
		new_calls = cur_calls;
		new_min0  = cur_min0;
		new_min1  = cur_min1;
		new_max0  = cur_max0;
		new_max1  = cur_max1;
		if (is_end) begin
			new_total = cur_total + TB'(dur_q);
			new_calls = cur_calls + 1'b1;
			new_min0  = (cur_min0 > mn1_q) ? mn1_q : cur_min0;
			new_min1  = (cur_min0 > mn1_q) ? cur_min0 : mn1_q;
			new_max0  = (cur_max0 < mx1_q) ? mx1_q : cur_max0;
			new_max1  = (cur_max0 < mx1_q) ? cur_max0 : mx1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			start_mem[idx_q] <= new_start;
			total_mem[idx_q] <= new_total;
			calls_mem[idx_q] <= new_calls;
			min0_mem[idx_q]  <= new_min0;
			min1_mem[idx_q]  <= new_min1;
			max0_mem[idx_q]  <= new_max0;
			max1_mem[idx_q]  <= new_max1;
			depth_mem[idx_q] <= new_depth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			used_q <= '0;
		end else if (cmd.wr) begin
			init_q[idx_q] <= 1'b1;
			if (op_q == rds_pkg::OP_BEGIN) used_q[idx_q] <= 1'b1;
		end
	end

	// trimmed sum in two subtract steps, then restoring divide one bit a cycle
	assign rem_try = {rem_q, num_q[TB-1]};
	assign rem_ge  = rem_try >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			if (cur_calls > CB'(rds_pkg::TRIM_CALLS)) begin
				num_q <= cur_total - TB'(cur_min0) - TB'(cur_min1);
				den_q <= cur_calls - CB'(rds_pkg::TRIM_CALLS);
			end else begin
				num_q <= cur_total;
				den_q <= cur_calls;
			end
		end else if (cmd.trim) begin
			if (cur_calls > CB'(rds_pkg::TRIM_CALLS)) begin
				num_q <= num_q - TB'(cur_max0) - TB'(cur_max1);
			end
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? CB'(rem_try - {1'b0, den_q}) : rem_try[CB-1:0];
			num_q <= {num_q[TB-2:0], rem_ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		if (stat.zero_calls) avg = '0;
		else if (num_q > TB'({FB{1'b1}})) avg = '1;
		else avg = num_q[FB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.slot_used     <= used_q[idx_q];
			out_q.average_ticks <= avg;
			out_q.min_ticks     <= FB'(cur_min0);
			out_q.max_ticks     <= FB'(cur_max0);
			out_q.call_count    <= cur_calls;
			out_q.depth_total   <= cur_depth;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign stat.in_range   = slot9 < 9'(SLOT_COUNT);
	assign stat.report     = op_q == rds_pkg::OP_REPORT;
	assign stat.zero_calls = cur_calls == '0;
	assign stat.div_last   = cnt_q == 6'(TB - 1);
	assign stat.out_busy   = out_valid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending result");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> den_q != '0)
		else $error("divide step with zero divisor");

	a_begin_used: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr && op_q == rds_pkg::OP_BEGIN) |=> used_q[idx_q])
		else $error("begin did not mark slot used");

endmodule

[sv/region_duration_statistics.sv]
// top level of the region duration statistics block
// depends on rds_pkg, rds_ctrl and rds_datapath
//
// input channel in_valid/in_ready/in_data carries events: begin, end,
// depth adjust and report, each naming a slot. only a report makes a
// result, delivered on out_valid/out_ready/out_data.
// begin, end and depth events pass accept, table read, duration,
// min/max insertion and table write. a report passes accept, table
// read, trim and the 64 step restoring divider for the mean; with no
// calls recorded it skips both. one item is in work at a time.
// events naming a slot beyond the table are dropped in the accept cycle.
// the finished result sits in an output register; the next event is
// accepted while it waits. a second report waits at the end of its work
// until the receiver takes the first one.
// reset clears the control state and the per slot valid bits, so every
// slot reads as empty right after reset with no clearing pass.
module region_duration_statistics #(
	parameter int SLOT_COUNT = rds_pkg::SLOT_COUNT_DEF,
	parameter int TIME_BITS  = rds_pkg::TIME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rds_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rds_pkg::out_t out_data
);

	rds_pkg::cmd_t  cmd;
	rds_pkg::stat_t stat;

	rds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rds_datapath #(
		.SLOT_COUNT (SLOT_COUNT),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
